// ===== hw/rtl/abst_pkg.sv =====
// shared types and codes for the array binary search tree unit
`timescale 1ns / 1ps

package abst_pkg;

    // transaction kinds
    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_INSERT   = 2'd1;
    localparam logic [1:0] KIND_PREORDER = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOROOM    = 3'd2;
    localparam logic [2:0] ST_TRAVERSAL = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    localparam int SLOT_BITS = 5;
    localparam int KEY_PORT_BITS = 16;

    typedef enum logic [3:0] {
        S_CLR,
        S_CLR_RPT,
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_PRE_KEY,
        S_PRE_RC,
        S_PRE_LC,
        S_PRE_EMIT,
        S_PRE_POP
    } t_state;

endpackage

// ===== hw/rtl/array_bst_insert_preorder_unit.sv =====
// binary search tree in heap-layout memory: clear, insert and preorder readout
`timescale 1ns / 1ps
// insert reads and compares one node per tree level walked (S_INS_RD, S_INS_CMP) and reports
// no room when the walk runs off the end; preorder visits each stored key through S_PRE_KEY,
// S_PRE_RC, S_PRE_LC, S_PRE_EMIT and S_PRE_POP; clear sweeps every slot, then reports; one
// transaction at a time, each result stall holds the sequencer; the node memory with one
// registered read a cycle sets the pace; reset: synchronous active low, then a clearing pass
// over the node memory during which o_stall is high; the output register is emptied at reset

module array_bst_insert_preorder_unit #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_key,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_key_out,
    output logic [4:0]  o_slot,
    output logic        o_last
);

    localparam int AW  = $clog2(SLOTS);     // node index bits
    localparam int ATW = AW + 2;            // child index can reach 2*SLOTS
    localparam int SPW = AW + 1;            // stack pointer holds SLOTS
    localparam int MW  = KEY_BITS + 1;      // node word: {valid, key}

    // node memory and index stack
    logic [MW-1:0] r_mem [SLOTS];
    logic [AW-1:0] r_stk [SLOTS];
    logic [MW-1:0] r_rdata;
    logic [AW-1:0] r_stk_rdata;

    // sequencer state
    abst_pkg::t_state r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_clr_rpt, n_clr_rpt;
    logic [ATW-1:0]      r_at, n_at;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]       r_cur, n_cur;
    logic [KEY_BITS-1:0] r_cur_key, n_cur_key;
    logic [SPW-1:0]      r_sp, n_sp;

    // output register
    logic                r_ov, n_ov;
    logic [2:0]          r_status, n_status;
    logic [15:0]         r_key_out, n_key_out;
    logic [4:0]          r_slot, n_slot;
    logic                r_last, n_last;

    // memory port controls
    logic                w_we;
    logic [AW-1:0]       w_wa;
    logic [MW-1:0]       w_wd;
    logic [AW-1:0]       w_ra;
    logic                w_swe;
    logic [AW-1:0]       w_swa;
    logic [AW-1:0]       w_swd;
    logic [AW-1:0]       w_sra;

    // helpers
    logic                in_acc;
    logic                out_free;
    logic [KEY_BITS-1:0] w_key_in;
    logic                w_rd_valid;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [ATW-1:0]      w_at_child;
    logic [ATW-1:0]      w_right, w_left;
    logic                w_right_ok, w_left_ok;
    logic [AW-1:0]       w_right_idx, w_left_idx;
    logic [AW+4:0]       w_at_pad, w_cur_pad;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != abst_pkg::S_IDLE);

    // key taken as its low KEY_BITS bits
    assign w_key_in   = KEY_BITS'(i_key);
    assign w_rd_valid = r_rdata[MW-1];
    assign w_rd_key   = r_rdata[KEY_BITS-1:0];

    // walk step: smaller keys go left, larger go right
    assign w_at_child = {1'b0, r_at[AW-1:0], 1'b0}
                      + ((r_key < w_rd_key) ? ATW'(1) : ATW'(2));

    // children of the node being traversed
    assign w_right     = {1'b0, r_cur, 1'b0} + ATW'(2);
    assign w_left      = {1'b0, r_cur, 1'b0} + ATW'(1);
    assign w_right_ok  = (w_right < ATW'(SLOTS));
    assign w_left_ok   = (w_left < ATW'(SLOTS));
    assign w_right_idx = w_right_ok ? w_right[AW-1:0] : '0;
    assign w_left_idx  = w_left_ok ? w_left[AW-1:0] : '0;

    // slot field reports the index modulo 32
    assign w_at_pad  = (AW+5)'(r_at[AW-1:0]);
    assign w_cur_pad = (AW+5)'(r_cur);

    // node memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    // index stack
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_stk[w_swa] <= w_swd;
        end
        r_stk_rdata <= r_stk[w_sra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= abst_pkg::S_CLR;
            r_clr_addr <= '0;
            r_clr_rpt  <= 1'b0;
            r_sp       <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_rpt  <= n_clr_rpt;
            r_sp       <= n_sp;
            r_ov       <= n_ov;
        end
        r_at      <= n_at;
        r_key     <= n_key;
        r_cur     <= n_cur;
        r_cur_key <= n_cur_key;
        r_status  <= n_status;
        r_key_out <= n_key_out;
        r_slot    <= n_slot;
        r_last    <= n_last;
    end

    // sequencer: next state, memory controls and result emission
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_clr_rpt  = r_clr_rpt;
        n_at       = r_at;
        n_key      = r_key;
        n_cur      = r_cur;
        n_cur_key  = r_cur_key;
        n_sp       = r_sp;
        n_ov       = r_ov && i_stall;
        n_status   = r_status;
        n_key_out  = r_key_out;
        n_slot     = r_slot;
        n_last     = r_last;
        w_we       = 1'b0;
        w_wa       = '0;
        w_wd       = '0;
        w_ra       = '0;
        w_swe      = 1'b0;
        w_swa      = r_sp[AW-1:0];
        w_swd      = '0;
        w_sra      = '0;

        case (r_state)
            // sweep every node to empty
            abst_pkg::S_CLR: begin
                w_we       = 1'b1;
                w_wa       = r_clr_addr;
                w_wd       = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(SLOTS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_rpt ? abst_pkg::S_CLR_RPT : abst_pkg::S_IDLE;
                end
            end
            abst_pkg::S_CLR_RPT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_status  = abst_pkg::ST_CLEARED;
                    n_key_out = '0;
                    n_slot    = '0;
                    n_last    = 1'b1;
                    n_clr_rpt = 1'b0;
                    n_state   = abst_pkg::S_IDLE;
                end
            end
            abst_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        abst_pkg::KIND_CLEAR: begin
                            n_clr_rpt = 1'b1;
                            n_state   = abst_pkg::S_CLR;
                        end
                        abst_pkg::KIND_INSERT: begin
                            n_at    = '0;
                            n_key   = w_key_in;
                            n_state = abst_pkg::S_INS_RD;
                        end
                        abst_pkg::KIND_PREORDER: begin
                            n_cur   = '0;
                            w_ra    = '0;
                            n_state = abst_pkg::S_PRE_KEY;
                        end
                        default: begin
                            n_state = abst_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            // insert: fetch the node on the walk, or report no room past the end
            abst_pkg::S_INS_RD: begin
                if (r_at < ATW'(SLOTS)) begin
                    w_ra    = r_at[AW-1:0];
                    n_state = abst_pkg::S_INS_CMP;
                end else if (out_free) begin
                    n_ov      = 1'b1;
                    n_status  = abst_pkg::ST_NOROOM;
                    n_key_out = 16'(r_key);
                    n_slot    = '0;
                    n_last    = 1'b1;
                    n_state   = abst_pkg::S_IDLE;
                end
            end
            abst_pkg::S_INS_CMP: begin
                w_ra = r_at[AW-1:0];
                if (!w_rd_valid) begin
                    if (out_free) begin
                        w_we      = 1'b1;
                        w_wa      = r_at[AW-1:0];
                        w_wd      = {1'b1, r_key};
                        n_ov      = 1'b1;
                        n_status  = abst_pkg::ST_INSERTED;
                        n_key_out = 16'(r_key);
                        n_slot    = w_at_pad[4:0];
                        n_last    = 1'b1;
                        n_state   = abst_pkg::S_IDLE;
                    end
                end else if (r_key == w_rd_key) begin
                    if (out_free) begin
                        n_ov      = 1'b1;
                        n_status  = abst_pkg::ST_DUPLICATE;
                        n_key_out = 16'(r_key);
                        n_slot    = w_at_pad[4:0];
                        n_last    = 1'b1;
                        n_state   = abst_pkg::S_IDLE;
                    end
                end else begin
                    n_at    = w_at_child;
                    n_state = abst_pkg::S_INS_RD;
                end
            end
            // preorder: node word of r_cur is in r_rdata
            abst_pkg::S_PRE_KEY: begin
                if (!w_rd_valid) begin
                    // only the root can be empty here
                    w_ra = r_cur;
                    if (out_free) begin
                        n_ov      = 1'b1;
                        n_status  = abst_pkg::ST_EMPTY;
                        n_key_out = '0;
                        n_slot    = '0;
                        n_last    = 1'b1;
                        n_state   = abst_pkg::S_IDLE;
                    end
                end else begin
                    n_cur_key = w_rd_key;
                    w_ra      = w_right_idx;
                    n_state   = abst_pkg::S_PRE_RC;
                end
            end
            // push right child first so the left one pops first
            abst_pkg::S_PRE_RC: begin
                if (w_right_ok && w_rd_valid && (r_sp < SPW'(SLOTS))) begin
                    w_swe = 1'b1;
                    w_swd = w_right_idx;
                    n_sp  = r_sp + SPW'(1);
                end
                w_ra    = w_left_idx;
                n_state = abst_pkg::S_PRE_LC;
            end
            abst_pkg::S_PRE_LC: begin
                if (w_left_ok && w_rd_valid && (r_sp < SPW'(SLOTS))) begin
                    w_swe = 1'b1;
                    w_swd = w_left_idx;
                    n_sp  = r_sp + SPW'(1);
                end
                n_state = abst_pkg::S_PRE_EMIT;
            end
            // emit the node; it is last when nothing is left to visit
            abst_pkg::S_PRE_EMIT: begin
                w_sra = r_sp[AW-1:0] - AW'(1);
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_status  = abst_pkg::ST_TRAVERSAL;
                    n_key_out = 16'(r_cur_key);
                    n_slot    = w_cur_pad[4:0];
                    n_last    = (r_sp == '0);
                    if (r_sp == '0) begin
                        n_state = abst_pkg::S_IDLE;
                    end else begin
                        n_sp    = r_sp - SPW'(1);
                        n_state = abst_pkg::S_PRE_POP;
                    end
                end
            end
            abst_pkg::S_PRE_POP: begin
                n_cur   = r_stk_rdata;
                w_ra    = r_stk_rdata;
                n_state = abst_pkg::S_PRE_KEY;
            end
            default: begin
                n_state = abst_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid   = r_ov;
    assign o_status  = r_status;
    assign o_key_out = r_key_out;
    assign o_slot    = r_slot;
    assign o_last    = r_last;

    // a clear transaction always runs a sweep, so the input side is held off next cycle
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == abst_pkg::KIND_CLEAR)) |=> o_stall)
        else $error("clear accepted without a sweep");

    // stack depth never passes the node count
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SLOTS))
        else $error("index stack overflow");

    // every traversal leaves the stack empty
    a_idle_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abst_pkg::S_IDLE) |-> (r_sp == '0))
        else $error("stack not empty when idle");

    // insert results are single and therefore last
    a_insert_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == abst_pkg::ST_INSERTED
                     || o_status == abst_pkg::ST_DUPLICATE
                     || o_status == abst_pkg::ST_NOROOM)) |-> o_last)
        else $error("insert result not flagged last");

endmodule
